FILE: rtl/core/integer_to_ascii_digits_defines.svh
// assertion macros for the integer to ascii digits block
`ifndef INTEGER_TO_ASCII_DIGITS_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define ITAD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("itad check failed");
// checked in every cycle, reset included
`define ITAD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("itad check failed");
`else
`define ITAD_ASSERT(label, prop)
`define ITAD_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: rtl/core/itad_pkg.sv
// types, constants and microprogram for the integer to ascii digits block
package itad_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned NumBcd     = 10;
    localparam int unsigned BcdWidth   = 4 * NumBcd;
    localparam int unsigned PcWidth    = 3;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [3:0] Radix   = 4'd10;

    localparam logic [5:0] DabbleSteps = 6'd32;
    localparam logic [3:0] DigitsFull  = 4'd10;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DABBLE,
        OP_STRIP,
        OP_EMIT_SIGN,
        OP_EMIT_DIGIT,
        OP_EMIT_LAST
    } t_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NOT_START,
        COND_CNT_NZ,
        COND_LEAD_ZERO,
        COND_NEG,
        COND_MORE
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic               gate;    // when set, op only runs when the condition holds
        logic [PcWidth-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic cnt_nz;
        logic lead_zero;
        logic neg;
        logic more;
    } t_flags;

    typedef struct packed {
        t_op  op;
        logic run;
    } t_exec;

    localparam logic [PcWidth-1:0] StepIdle   = 3'd0;
    localparam logic [PcWidth-1:0] StepDabble = 3'd1;
    localparam logic [PcWidth-1:0] StepStrip  = 3'd2;
    localparam logic [PcWidth-1:0] StepSign   = 3'd3;
    localparam logic [PcWidth-1:0] StepDigit  = 3'd4;
    localparam logic [PcWidth-1:0] StepLast   = 3'd5;

    // microprogram: a true condition jumps to target, otherwise fall through
    function automatic t_ctrl itad_rom(input logic [PcWidth-1:0] pc);
        t_ctrl w;
        case (pc)
            StepIdle:   w = '{op: OP_LOAD,       cond: COND_NOT_START, gate: 1'b0,
                              target: StepIdle};
            StepDabble: w = '{op: OP_DABBLE,     cond: COND_CNT_NZ,    gate: 1'b1,
                              target: StepDabble};
            StepStrip:  w = '{op: OP_STRIP,      cond: COND_LEAD_ZERO, gate: 1'b1,
                              target: StepStrip};
            StepSign:   w = '{op: OP_EMIT_SIGN,  cond: COND_NEG,       gate: 1'b1,
                              target: StepDigit};
            StepDigit:  w = '{op: OP_EMIT_DIGIT, cond: COND_MORE,      gate: 1'b1,
                              target: StepDigit};
            StepLast:   w = '{op: OP_EMIT_LAST,  cond: COND_ALWAYS,    gate: 1'b0,
                              target: StepIdle};
            default:    w = '{op: OP_NONE,       cond: COND_ALWAYS,    gate: 1'b0,
                              target: StepIdle};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] itad_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < Radix) begin
            c = ChZero + {4'd0, d};
        end else begin
            c = ChA + {4'd0, d - Radix};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/itad_seq.sv
// microcode sequencer: step counter, control rom and jump logic
module itad_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itad_pkg::t_flags i_flags,
    output itad_pkg::t_exec o_exec,
    output logic            o_busy
);
    import itad_pkg::*;

    logic [PcWidth-1:0] r_pc;
    logic [PcWidth-1:0] n_pc;
    t_ctrl              w_ctrl;
    logic               w_cond;

    assign w_ctrl = itad_rom(r_pc);

    always_comb begin
        case (w_ctrl.cond)
            COND_ALWAYS:    w_cond = 1'b1;
            COND_NOT_START: w_cond = !i_flags.start;
            COND_CNT_NZ:    w_cond = i_flags.cnt_nz;
            COND_LEAD_ZERO: w_cond = i_flags.lead_zero;
            COND_NEG:       w_cond = i_flags.neg;
            COND_MORE:      w_cond = i_flags.more;
            default:        w_cond = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = w_cond ? w_ctrl.target : r_pc + 1'b1;
    end

    assign o_exec.op  = w_ctrl.op;
    assign o_exec.run = !w_ctrl.gate || w_cond;
    assign o_busy     = (r_pc != StepIdle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= StepIdle;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: rtl/core/integer_to_ascii_digits.sv
// top level: 32-bit word to ascii decimal or hex characters
//
//  channel | direction | transfer when       | payload
//  --------+-----------+---------------------+-------------------------
//  command | in        | start & !busy       | i_value, i_hex_mode
//  result  | out       | o_strobe (1 cycle)  | o_character, o_last
//
// a command lasts as long whatever its value, for a given mode:
//   load, double-dabble loop in decimal (no shifts in hex), then print
// strips trade one for one with digits, and the sign slot is spent even when positive
// busy falls with the last character, which shows in the first cycle with busy low
// synchronous active-low reset clears the step counter and strobe only
// the receiver cannot stall: each character is taken in its one cycle
module integer_to_ascii_digits (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [itad_pkg::ValueWidth-1:0] i_value,
    input  logic                          i_hex_mode,
    output logic [7:0]                    o_character,
    output logic                          o_last,
    output logic                          o_strobe
);
    import itad_pkg::*;
    `include "integer_to_ascii_digits_defines.svh"

    // datapath registers
    logic [ValueWidth-1:0] r_bin;    // binary shifted out during conversion
    logic [BcdWidth-1:0]   r_bcd;    // digit nibbles, most significant on top
    logic [5:0]            r_cnt;    // shift-add steps left
    logic [3:0]            r_ndig;   // nibbles still to strip or print
    logic                  r_neg;
    logic [7:0]            r_char;
    logic                  r_last;
    logic                  r_strobe;

    logic [ValueWidth-1:0] n_bin;
    logic [BcdWidth-1:0]   n_bcd;
    logic [5:0]            n_cnt;
    logic [3:0]            n_ndig;
    logic                  n_neg;
    logic [7:0]            n_char;
    logic                  n_last;
    logic                  n_strobe;

    logic [BcdWidth-1:0]   w_adj;
    logic [3:0]            w_top;
    t_flags                w_flags;
    t_exec                 w_exec;

    itad_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_exec  (w_exec),
        .o_busy  (busy)
    );

    assign w_top = r_bcd[BcdWidth-1 -: 4];

    assign w_flags.start     = start;
    assign w_flags.cnt_nz    = (r_cnt != '0);
    assign w_flags.lead_zero = (w_top == 4'd0) && (r_ndig > 4'd1);
    assign w_flags.neg       = r_neg;
    assign w_flags.more      = (r_ndig > 4'd1);

    // add 3 to every nibble of five or more before the shift
    always_comb begin
        for (int i = 0; i < NumBcd; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_ndig   = r_ndig;
        n_neg    = r_neg;
        n_char   = r_char;
        n_last   = r_last;
        n_strobe = 1'b0;
        if (w_exec.run) begin
            case (w_exec.op)
                OP_LOAD: begin
                    n_ndig = DigitsFull;
                    if (i_hex_mode) begin
                        // nibbles are the hex digits already
                        n_neg = 1'b0;
                        n_bin = '0;
                        n_bcd = {{(BcdWidth-ValueWidth){1'b0}}, i_value};
                        n_cnt = '0;
                    end else begin
                        // magnitude of the most negative word still fits unsigned
                        n_neg = i_value[ValueWidth-1];
                        n_bin = i_value[ValueWidth-1] ? (~i_value + 1'b1) : i_value;
                        n_bcd = '0;
                        n_cnt = DabbleSteps;
                    end
                end
                OP_DABBLE: begin
                    n_bcd = {w_adj[BcdWidth-2:0], r_bin[ValueWidth-1]};
                    n_bin = {r_bin[ValueWidth-2:0], 1'b0};
                    n_cnt = r_cnt - 1'b1;
                end
                OP_STRIP: begin
                    n_bcd  = {r_bcd[BcdWidth-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end
                OP_EMIT_SIGN: begin
                    n_char   = ChMinus;
                    n_last   = 1'b0;
                    n_strobe = 1'b1;
                end
                OP_EMIT_DIGIT: begin
                    n_char   = itad_char(w_top);
                    n_last   = 1'b0;
                    n_strobe = 1'b1;
                    n_bcd    = {r_bcd[BcdWidth-5:0], 4'd0};
                    n_ndig   = r_ndig - 1'b1;
                end
                OP_EMIT_LAST: begin
                    n_char   = itad_char(w_top);
                    n_last   = 1'b1;
                    n_strobe = 1'b1;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_strobe    = r_strobe;

    // a character only follows a cycle of work
    `ITAD_ASSERT(a_strobe_after_busy, o_strobe |-> $past(busy))
    // an accepted command keeps the block busy in the next cycle
    `ITAD_ASSERT(a_start_busy, (start && !busy) |=> busy)
    // the final character closes the command: busy already dropped
    `ITAD_ASSERT(a_last_ends_cmd, (o_strobe && o_last) |-> !busy)
    // no character comes out of reset
    `ITAD_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_strobe)

endmodule
